/* src/hnbf_pkg.sv */
// ----------------------------------------------------------------------------
// hnbf_pkg
// Shared types and constants for the HDLC NRZI bit-stuffing framer.
// ----------------------------------------------------------------------------
`default_nettype none

package hnbf_pkg;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned RUN_W    = 3;
    localparam int unsigned CNT_W    = 5;

    localparam logic [REQ_W-1:0] REQ_DATA  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FLAG  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CRC   = 2'd3;

    localparam logic [CRC_W-1:0] CRC_POLY  = 16'h8408;
    localparam logic [CRC_W-1:0] CRC_INIT  = 16'hFFFF;
    localparam logic [RUN_W-1:0] STUFF_RUN = 3'd5;
    localparam logic [RUN_W-1:0] RUN_MAX   = 3'd7;
    localparam logic [CNT_W-1:0] BYTE_BITS = 5'd8;
    localparam logic [CNT_W-1:0] CRC_BITS  = 5'd16;

    typedef struct packed {
        logic clr;
        logic step;
        logic bit_in;
    } t_crc_ctl;

endpackage

`default_nettype wire

/* src/hnbf_if.sv */
// ----------------------------------------------------------------------------
// hnbf_req_if / hnbf_sym_if
// Valid/ready channels for framer requests and output tone symbols.
// ----------------------------------------------------------------------------
`default_nettype none

interface hnbf_req_if;
    import hnbf_pkg::*;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface hnbf_sym_if;
    logic valid;
    logic ready;
    logic tone;
    logic stuffed;
    logic last;
    modport source (output valid, output tone, output stuffed, output last, input ready);
    modport sink   (input valid, input tone, input stuffed, input last, output ready);
endinterface

`default_nettype wire

/* src/hnbf_crc.sv */
// ----------------------------------------------------------------------------
// hnbf_crc
// Bit-serial reflected CRC-16 register, one data bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module hnbf_crc
    import hnbf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_crc_ctl         i_ctl,
    output logic [CRC_W-1:0]      o_crc
);

    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;
    logic             fb;

    always_comb begin
        fb    = r_crc[0] ^ i_ctl.bit_in;
        n_crc = r_crc;
        if (i_ctl.clr) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.step) begin
            n_crc = {1'b0, r_crc[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

/* src/hdlc_nrzi_bit_stuffing_framer.sv */
// ----------------------------------------------------------------------------
// hdlc_nrzi_bit_stuffing_framer
// HDLC transmit line coder: LSB-first bits, NRZI tone, bit stuffing, CRC-16.
//
//   channel  dir  modport  payload
//   i_req    in   sink     req_type[1:0], data_byte[7:0]
//   o_sym    out  source   tone, stuffed, last
//
// One symbol per cycle, when not stalled, from a shift register walked by a small sequencer.
// A byte is 8 to 10 symbols and a send-CRC request 16 to 20, and the input
// is held off while they go out; a clear sends no symbol.
// A new request is taken only when the sequencer is idle; the output
// register lets the last symbol wait while the next request is taken.
// A stalled output freezes the sequencer. Synchronous active-low reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_nrzi_bit_stuffing_framer
    import hnbf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hnbf_req_if.sink   i_req,
    hnbf_sym_if.source o_sym
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BIT   = 2'd1;
    localparam logic [1:0] ST_STUFF = 2'd2;

    logic [1:0]       r_state,    n_state;
    logic [CRC_W-1:0] r_shift,    n_shift;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic             r_stuff_on, n_stuff_on;
    logic             r_tone,     n_tone;
    logic [RUN_W-1:0] r_run,      n_run;
    logic             r_o_valid,  n_o_valid;
    logic             r_o_tone,   n_o_tone;
    logic             r_o_stuffed, n_o_stuffed;
    logic             r_o_last,   n_o_last;

    t_crc_ctl         crc_ctl;
    logic [CRC_W-1:0] crc;
    logic             req_acc;
    logic             can_adv;
    logic [RUN_W-1:0] run_inc;

    hnbf_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign can_adv     = (r_state != ST_IDLE) && (!r_o_valid || o_sym.ready);
    assign run_inc     = (r_run == RUN_MAX) ? r_run : r_run + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_cnt       = r_cnt;
        n_stuff_on  = r_stuff_on;
        n_tone      = r_tone;
        n_run       = r_run;
        n_o_valid   = r_o_valid && !o_sym.ready;
        n_o_tone    = r_o_tone;
        n_o_stuffed = r_o_stuffed;
        n_o_last    = r_o_last;
        crc_ctl     = '0;

        if (req_acc) begin
            unique case (i_req.req_type)
                REQ_DATA, REQ_FLAG: begin
                    n_shift    = {{(CRC_W-BYTE_W){1'b0}}, i_req.data_byte};
                    n_cnt      = BYTE_BITS;
                    n_stuff_on = (i_req.req_type == REQ_DATA);
                    n_state    = ST_BIT;
                end
                REQ_CLEAR: begin
                    crc_ctl.clr = 1'b1;
                end
                REQ_CRC: begin
                    n_shift    = ~crc;
                    n_cnt      = CRC_BITS;
                    n_stuff_on = 1'b1;
                    n_state    = ST_BIT;
                end
                default: ;
            endcase
        end

        if (can_adv) begin
            n_o_valid = 1'b1;
            unique case (r_state)
                ST_BIT: begin
                    crc_ctl.step   = 1'b1;
                    crc_ctl.bit_in = r_shift[0];
                    n_shift        = {1'b0, r_shift[CRC_W-1:1]};
                    n_cnt          = r_cnt - 1'b1;
                    n_o_stuffed    = 1'b0;
                    if (r_shift[0]) begin
                        n_run    = run_inc;
                        n_o_tone = r_tone;
                        if (r_stuff_on && run_inc == STUFF_RUN) begin
                            n_state  = ST_STUFF;
                            n_o_last = 1'b0;
                        end else begin
                            n_o_last = (r_cnt == 5'd1);
                            n_state  = (r_cnt == 5'd1) ? ST_IDLE : ST_BIT;
                        end
                    end else begin
                        n_run    = '0;
                        n_tone   = ~r_tone;
                        n_o_tone = ~r_tone;
                        n_o_last = (r_cnt == 5'd1);
                        n_state  = (r_cnt == 5'd1) ? ST_IDLE : ST_BIT;
                    end
                end
                ST_STUFF: begin
                    n_run       = '0;
                    n_tone      = ~r_tone;
                    n_o_tone    = ~r_tone;
                    n_o_stuffed = 1'b1;
                    n_o_last    = (r_cnt == '0);
                    n_state     = (r_cnt == '0) ? ST_IDLE : ST_BIT;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_stuff_on <= 1'b0;
            r_tone     <= 1'b0;
            r_run      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_stuff_on <= n_stuff_on;
            r_tone     <= n_tone;
            r_run      <= n_run;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift     <= n_shift;
        r_o_tone    <= n_o_tone;
        r_o_stuffed <= n_o_stuffed;
        r_o_last    <= n_o_last;
    end

    assign o_sym.valid   = r_o_valid;
    assign o_sym.tone    = r_o_tone;
    assign o_sym.stuffed = r_o_stuffed;
    assign o_sym.last    = r_o_last;

`ifndef SYNTHESIS
    a_stuff_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STUFF) |-> r_stuff_on)
        else $error("stuff state entered with stuffing disabled");

    a_stuffed_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sym.valid && o_sym.stuffed) |-> (r_run == '0))
        else $error("run not cleared after stuffed symbol");

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt == '0))
        else $error("bits left while idle");

    a_stuffed_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (can_adv && r_state == ST_STUFF) |=> (r_tone != $past(r_tone)))
        else $error("stuffed symbol did not toggle tone");
`endif

endmodule

`default_nettype wire

/* tb/sv/hnbf_line_code_checker.sv */
// ----------------------------------------------------------------------------
// hnbf_line_code_checker
// Watches the request and symbol channels of the HDLC framer, keeps its
// own copy of the CRC, NRZI level and ones run, turns every accepted
// request into the tone symbols it must produce and compares each
// accepted symbol against the oldest one still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module hnbf_line_code_checker
    import hnbf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire logic              i_req_ready,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_sym_valid,
    input  wire logic              i_sym_ready,
    input  wire logic              i_tone,
    input  wire logic              i_stuffed,
    input  wire logic              i_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_symbol_count,
    output int                     o_stuffed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic tone;
        logic stuffed;
        logic last;
    } t_symbol;

    t_symbol          owed_symbols[$];
    logic [CRC_W-1:0] crc_acc   = CRC_INIT;
    logic             tone_lvl  = 1'b0;
    logic [RUN_W-1:0] ones_cnt  = '0;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_symbol_count  = 0;
        o_stuffed_count = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_fail_count < 100)
            $display("%0t: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic void owe_symbol(input logic stuffed);
        t_symbol s;
        s.tone    = tone_lvl;
        s.stuffed = stuffed;
        s.last    = 1'b0;
        owed_symbols.push_back(s);
    endfunction

    function automatic void crc_shift(input logic b);
        logic fb;
        fb      = crc_acc[0] ^ b;
        crc_acc = crc_acc >> 1;
        if (fb)
            crc_acc = crc_acc ^ CRC_POLY;
    endfunction

    function automatic void code_byte(input logic [BYTE_W-1:0] value, input logic stuff_en);
        logic b;
        for (int i = 0; i < BYTE_W; i++) begin
            b = value[i];
            crc_shift(b);
            if (b) begin
                owe_symbol(1'b0);
                if (ones_cnt != RUN_MAX)
                    ones_cnt = ones_cnt + 1'b1;
                if (stuff_en && ones_cnt == STUFF_RUN) begin
                    tone_lvl = ~tone_lvl;
                    owe_symbol(1'b1);
                    ones_cnt = '0;
                end
            end else begin
                tone_lvl = ~tone_lvl;
                owe_symbol(1'b0);
                ones_cnt = '0;
            end
        end
    endfunction

    function automatic void code_request(input logic [REQ_W-1:0] req,
                                         input logic [BYTE_W-1:0] value);
        int               start_size;
        logic [CRC_W-1:0] fcs;
        start_size = owed_symbols.size();
        case (req)
            REQ_DATA: begin
                code_byte(value, 1'b1);
            end
            REQ_FLAG: begin
                code_byte(value, 1'b0);
            end
            REQ_CLEAR: begin
                crc_acc = CRC_INIT;
            end
            default: begin
                fcs = ~crc_acc;
                code_byte(fcs[7:0], 1'b1);
                code_byte(fcs[15:8], 1'b1);
            end
        endcase
        if (owed_symbols.size() > start_size)
            owed_symbols[owed_symbols.size()-1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_symbol want;
        if (!i_rst_n) begin
            crc_acc  <= CRC_INIT;
            tone_lvl <= 1'b0;
            ones_cnt <= '0;
        end else begin
            if (i_sym_valid && i_sym_ready) begin
                o_symbol_count++;
                if (i_stuffed === 1'b1)
                    o_stuffed_count++;
                if (owed_symbols.size() == 0) begin
                    report_mismatch($sformatf("unexpected symbol tone=%b stuffed=%b last=%b",
                                              i_tone, i_stuffed, i_last));
                end else begin
                    want = owed_symbols.pop_front();
                    if (i_tone !== want.tone || i_stuffed !== want.stuffed
                            || i_last !== want.last)
                        report_mismatch($sformatf(
                            "symbol %0d: tone=%b/%b stuffed=%b/%b last=%b/%b (got/want)",
                            o_symbol_count, i_tone, want.tone, i_stuffed, want.stuffed,
                            i_last, want.last));
                end
            end
            if (i_req_valid && i_req_ready)
                code_request(i_req_type, i_data_byte);
            o_pending <= owed_symbols.size();
        end
    end

endmodule

`default_nettype wire

/* tb/sv/hdlc_nrzi_bit_stuffing_framer_test.sv */
// ----------------------------------------------------------------------------
// hdlc_nrzi_bit_stuffing_framer_test
// Drives the framer with a directed set of corner bytes, flags, CRC clears
// and CRC sends, then with random HDLC-style frames mixed with noise,
// while both channels idle at random and the output is once held off for
// a long stretch. The checker beside the block predicts every symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_nrzi_bit_stuffing_framer_test;
    import hnbf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 435;
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_DIRECTED = 25;

    logic i_clk;
    logic i_rst_n;

    hnbf_req_if req_if ();
    hnbf_sym_if sym_if ();

    int fail_count;
    int pending;
    int symbol_count;
    int stuffed_count;
    int req_count;
    int frame_count;
    bit hold_off_req;
    bit hold_done;

    hdlc_nrzi_bit_stuffing_framer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_sym   (sym_if)
    );

    hnbf_line_code_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_if.valid),
        .i_req_ready     (req_if.ready),
        .i_req_type      (req_if.req_type),
        .i_data_byte     (req_if.data_byte),
        .i_sym_valid     (sym_if.valid),
        .i_sym_ready     (sym_if.ready),
        .i_tone          (sym_if.tone),
        .i_stuffed       (sym_if.stuffed),
        .i_last          (sym_if.last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_symbol_count  (symbol_count),
        .o_stuffed_count (stuffed_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 4))
            0:       return 8'hFF;
            1:       return 8'($urandom | $urandom);
            2:       return 8'($urandom | $urandom | $urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    // one transaction on the request channel, preceded by a random gap
    task automatic issue(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] value);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= req;
        req_if.data_byte <= value;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        req_count++;
        if (req_count >= NUM_DIRECTED + 200 && !hold_done) begin
            hold_done    = 1'b1;
            hold_off_req = 1'b1;
        end
    endtask

    task automatic send_frame();
        int n_bytes;
        n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
        repeat ($urandom_range(1, 2)) issue(REQ_FLAG, 8'h7E);
        issue(REQ_CLEAR, 8'($urandom));
        repeat (n_bytes) issue(REQ_DATA, pick_byte());
        issue(REQ_CRC, 8'($urandom));
        issue(REQ_FLAG, 8'h7E);
        frame_count++;
    endtask

    // output side: random bursts and gaps, one long hold-off on request
    initial begin : sink_side
        int run_len;
        int gap_len;
        sym_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                sym_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 8);
            sym_if.ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            gap_len = idle_len();
            if (gap_len > 0) begin
                sym_if.ready <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [REQ_W-1:0]  dir_req  [NUM_DIRECTED];
        logic [BYTE_W-1:0] dir_byte [NUM_DIRECTED];
        dir_req  = '{REQ_DATA, REQ_DATA, REQ_DATA, REQ_FLAG, REQ_FLAG,
                     REQ_DATA, REQ_DATA, REQ_CRC, REQ_CLEAR, REQ_CRC,
                     REQ_CLEAR, REQ_DATA, REQ_DATA, REQ_DATA, REQ_CRC,
                     REQ_FLAG, REQ_FLAG, REQ_DATA, REQ_DATA, REQ_CLEAR,
                     REQ_CLEAR, REQ_DATA, REQ_DATA, REQ_CRC, REQ_FLAG};
        dir_byte = '{8'h00, 8'hFF, 8'h1F, 8'h7E, 8'hFF,
                     8'h01, 8'hFE, 8'h00, 8'hA5, 8'hFF,
                     8'h00, 8'h55, 8'hAA, 8'h80, 8'h3C,
                     8'h00, 8'h7E, 8'h7E, 8'hF8, 8'hFF,
                     8'h00, 8'hFF, 8'hFF, 8'hC3, 8'h7E};
        req_count    = 0;
        frame_count  = 0;
        hold_off_req = 1'b0;
        hold_done    = 1'b0;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= REQ_DATA;
        req_if.data_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            issue(dir_req[i], dir_byte[i]);

        while (req_count < NUM_DIRECTED + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 80)
                send_frame();
            else
                repeat ($urandom_range(1, 4))
                    issue(2'($urandom), 8'($urandom));
        end
        req_if.valid <= 1'b0;

        // let the checker publish the symbols owed for the last transaction
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests, %0d after the directed set, %0d framed sequences.",
                 req_count, req_count - NUM_DIRECTED, frame_count);
        $display("Checked %0d tone symbols (%0d stuffed), with one %0d-cycle output hold-off.",
                 symbol_count, stuffed_count, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
